// ----- rtl/core/plis_pkg.sv -----
// ----------------------------------------------------------------------------
// plis_pkg
// Shared constants, types and codes of the prefix LIS max-tree engine.
// ----------------------------------------------------------------------------
package plis_pkg;

  localparam int VALUE_BITS  = 10;
  localparam int LENGTH_BITS = 16;

  // Tree nodes 1 .. 2*LEAF_COUNT-1; entry 0 is never used
  localparam int NODE_BITS   = VALUE_BITS + 1;
  localparam int NODE_COUNT  = 1 << NODE_BITS;
  localparam int LEAF_COUNT  = 1 << VALUE_BITS;
  localparam int SUM_BITS    = NODE_BITS + 1;
  localparam int LVL_BITS    = $clog2(VALUE_BITS + 2);

  localparam logic [LVL_BITS-1:0]    LVL_LAST   = LVL_BITS'(VALUE_BITS + 1);
  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

  typedef logic [VALUE_BITS-1:0]  value_t;
  typedef logic [LENGTH_BITS-1:0] length_t;
  typedef logic [NODE_BITS-1:0]   node_addr_t;
  typedef logic [LVL_BITS-1:0]    lvl_t;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RAISE,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic       we;
    node_addr_t waddr;
    length_t    wdata;
    logic       re;
    node_addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic   start;
    logic   operation;
    value_t value;
    logic   slot_free;
  } seq_cmd_t;

  typedef struct packed {
    logic    ready;
    logic    done;
    length_t length;
  } seq_stat_t;

endpackage

// ----- rtl/core/plis_ram.sv -----
// ----------------------------------------------------------------------------
// plis_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module plis_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/plis_seq.sv -----
// ----------------------------------------------------------------------------
// plis_seq
// Sequencer of the max tree: clearing pass, prefix scan one level a cycle,
// then, for a push, read-modify-write of the leaf-to-root path one level a cycle.
// ----------------------------------------------------------------------------
module plis_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  plis_pkg::seq_cmd_t  cmd,
  output plis_pkg::seq_stat_t stat,
  output plis_pkg::mem_req_t  mem_req,
  input  plis_pkg::length_t   mem_rdata
);

  import plis_pkg::*;

  seq_state_t state_r, state_nxt;
  node_addr_t clr_r, clr_nxt;
  logic       op_r, op_nxt;
  node_addr_t hi_r, hi_nxt;
  lvl_t       lvl_r, lvl_nxt;
  length_t    best_r, best_nxt;
  length_t    len_r, len_nxt;
  logic       rd_pend_r, rd_pend_nxt;
  node_addr_t waddr_r, waddr_nxt;

  logic [SUM_BITS-1:0] node_sum;
  logic [SUM_BITS-1:0] node_shift;
  logic [SUM_BITS-1:0] sib_node;
  node_addr_t          hi_shift;
  length_t             best_acc;

  // Node on the leaf path at the current level, and its left neighbour
  assign node_sum   = SUM_BITS'(LEAF_COUNT) + {1'b0, hi_r};
  assign node_shift = node_sum >> lvl_r;
  assign sib_node   = node_shift - SUM_BITS'(1);
  assign hi_shift   = hi_r >> lvl_r;
  assign best_acc   = (rd_pend_r && (mem_rdata > best_r)) ? mem_rdata : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    hi_r    <= hi_nxt;
    lvl_r   <= lvl_nxt;
    best_r  <= best_nxt;
    len_r   <= len_nxt;
    waddr_r <= waddr_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (lvl_r == LVL_LAST) state_nxt = (op_r == OP_PUSH) ? ST_RAISE : ST_DONE;
      end
      ST_RAISE: begin
        if (lvl_r == LVL_LAST) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (cmd.slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt     = clr_r;
    op_nxt      = op_r;
    hi_nxt      = hi_r;
    lvl_nxt     = lvl_r;
    best_nxt    = best_r;
    len_nxt     = len_r;
    rd_pend_nxt = 1'b0;
    waddr_nxt   = waddr_r;
    mem_req     = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = '0;
        clr_nxt       = clr_r + NODE_BITS'(1);
      end
      ST_IDLE: begin
        if (cmd.start) begin
          op_nxt   = cmd.operation;
          // a query bound is inclusive: scan leaves below bound plus one
          hi_nxt   = (cmd.operation == OP_QUERY) ? ({1'b0, cmd.value} + NODE_BITS'(1))
                                                 : {1'b0, cmd.value};
          lvl_nxt  = '0;
          best_nxt = '0;
        end
      end
      ST_SCAN: begin
        best_nxt = best_acc;
        if (lvl_r != LVL_LAST) begin
          if (hi_shift[0]) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = sib_node[NODE_BITS-1:0];
            rd_pend_nxt   = 1'b1;
          end
          lvl_nxt = lvl_r + LVL_BITS'(1);
        end else begin
          lvl_nxt = '0;
          if (op_r == OP_PUSH) begin
            len_nxt = (best_acc == LENGTH_MAX) ? LENGTH_MAX : best_acc + LENGTH_BITS'(1);
          end else begin
            len_nxt = best_acc;
          end
        end
      end
      ST_RAISE: begin
        if (rd_pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = waddr_r;
          mem_req.wdata = (mem_rdata > len_r) ? mem_rdata : len_r;
        end
        if (lvl_r != LVL_LAST) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = node_shift[NODE_BITS-1:0];
          waddr_nxt     = node_shift[NODE_BITS-1:0];
          rd_pend_nxt   = 1'b1;
          lvl_nxt       = lvl_r + LVL_BITS'(1);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign stat.ready  = (state_r == ST_IDLE);
  assign stat.done   = (state_r == ST_DONE);
  assign stat.length = len_r;

  a_no_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR && mem_req.we) |-> (mem_req.waddr != '0))
    else $error("tree write to unused entry zero");

  a_raise_covers_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RAISE && mem_req.we) |-> (mem_req.wdata >= len_r))
    else $error("raise wrote a value below the new length");

  a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && op_r == OP_PUSH) |-> (len_r != '0))
    else $error("push produced a zero length");

  a_scan_one_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN && state_r != ST_RAISE) |-> !mem_req.re)
    else $error("tree read outside scan or raise");

endmodule

// ----- rtl/core/prefix_lis_max_tree.sv -----
// ----------------------------------------------------------------------------
// prefix_lis_max_tree
// Longest strictly increasing subsequence engine over a max tree of value
// ranks, kept in one RAM; push items extend and record, queries read back.
//
//   channel | direction | ports                          | transaction
//   in      | input     | in_valid/in_ready, operation,  | one push or query
//           |           | value                          |
//   out     | output    | out_valid/out_ready, length    | one length per item
//
// The tree RAM's single read port is walked one level a cycle, first over
// the prefix nodes, then, for a push only, read-modify-write over the
// leaf-to-root path.
// After reset a clearing pass writes zero to all 2^(VALUE_BITS+1) entries;
// in_ready stays low meanwhile.
// A result waits in the output register; a new item is accepted meanwhile,
// and stalls at its end only if the previous result is still untaken.
// ----------------------------------------------------------------------------
module prefix_lis_max_tree (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  plis_pkg::value_t    in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output plis_pkg::length_t   out_length
);

  import plis_pkg::*;

  seq_cmd_t  cmd;
  seq_stat_t stat;
  mem_req_t  mem_req;
  length_t   mem_rdata;

  logic    out_valid_r, out_valid_nxt;
  length_t out_length_r, out_length_nxt;
  logic    slot_free;

  assign slot_free     = !out_valid_r || out_ready;
  assign cmd.start     = in_valid && stat.ready;
  assign cmd.operation = in_operation;
  assign cmd.value     = in_value;
  assign cmd.slot_free = slot_free;

  plis_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  plis_ram #(
    .WIDTH (LENGTH_BITS),
    .DEPTH (NODE_COUNT)
  ) u_tree_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // load a finished result into a free slot, drop it when taken
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_length_nxt = out_length_r;
    if (stat.done && slot_free) begin
      out_valid_nxt  = 1'b1;
      out_length_nxt = stat.length;
    end else if (out_ready) begin
      out_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_length_r <= out_length_nxt;
  end

  assign in_ready   = stat.ready;
  assign out_valid  = out_valid_r;
  assign out_length = out_length_r;

endmodule
